[rtl/swipe_gesture_menu_selector_assert.svh]
// Assertion macros for the RTL of the swipe gesture menu selector.
`ifndef SWIPE_GESTURE_MENU_SELECTOR_ASSERT_SVH
`define SWIPE_GESTURE_MENU_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SGMS_ASSERT_IMP(lbl, clk_s, rst_s, a, b) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |-> (b)) \
        else $error("sgms: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SGMS_ASSERT_NXT(lbl, clk_s, rst_s, a, b) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |=> (b)) \
        else $error("sgms: next-cycle check failed");

`endif

[rtl/sgms_pkg.sv]
`timescale 1ns / 1ps

package sgms_pkg;

    // Configuration register reset values
    localparam logic [7:0]  SWIPE_THRESHOLD_RST = 8'd82;
    localparam logic [7:0]  LOCK_SAMPLES_RST    = 8'd20;
    localparam logic [15:0] BLINK_PERIOD_RST    = 16'd15;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SWIPE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCK_SAMPLES    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PERIOD    = 2'd2;

    // Item kinds
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Gesture codes
    localparam logic [1:0] GEST_NONE = 2'd0;
    localparam logic [1:0] GEST_NEXT = 2'd1;
    localparam logic [1:0] GEST_PREV = 2'd2;

    // Menu entries
    localparam logic [1:0] ENTRY_ZERO  = 2'd0;
    localparam logic [1:0] ENTRY_ONE   = 2'd1;
    localparam logic [1:0] ENTRY_BLINK = 2'd2;
    localparam logic [1:0] ENTRY_THREE = 2'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] left_level;
        logic [7:0] right_level;
    } item_t;

    typedef struct packed {
        logic [1:0] menu_entry;
        logic [1:0] gesture_seen;
        logic       led_one;
        logic       led_two;
        logic       led_three;
    } result_t;

    typedef struct packed {
        logic [7:0]  swipe_threshold;
        logic [7:0]  lock_samples;
        logic [15:0] blink_period;
    } cfg_t;

endpackage

[rtl/swipe_gesture_menu_selector.sv]
`timescale 1ns / 1ps
// Channel   Signals                              Beat
// item      item_valid, item_ready, item         one sample or tick
// result    result_valid, result_ready, result   one result per item
// config    cfg_we, cfg_index, cfg_data          one register write
//
// An item is registered in the input register on entry and its result in the
// output register; one item per cycle sustained while result_ready is high.
// The engine state steps once per item, as it moves to the output register.
// Reset (rst_n low) clears flags and engine state, restores register defaults.
// A stalled result holds in the output register; the input register still
// takes one more item, then item_ready drops until the result moves.

`include "swipe_gesture_menu_selector_assert.svh"

module swipe_gesture_menu_selector
    import sgms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;
    cfg_t    cfg;
    result_t step_result;

    // Pipeline flow
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    sgms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sgms_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `SGMS_ASSERT_NXT(a_advance_fills, clk, rst_n, advance, result_valid)
    `SGMS_ASSERT_NXT(a_accept_holds, clk, rst_n, item_valid && item_ready, item_valid_reg)
    `SGMS_ASSERT_IMP(a_blink_leds, clk, rst_n, result_valid && result.menu_entry == ENTRY_BLINK, !result.led_one && !result.led_three)
    `SGMS_ASSERT_IMP(a_entry_one_leds, clk, rst_n, result_valid && result.menu_entry == ENTRY_ONE, result.led_two && !result.led_one && !result.led_three)

endmodule

[rtl/sgms_cfg.sv]
`timescale 1ns / 1ps

module sgms_cfg
    import sgms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // Register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swipe_threshold <= SWIPE_THRESHOLD_RST;
            cfg_reg.lock_samples    <= LOCK_SAMPLES_RST;
            cfg_reg.blink_period    <= BLINK_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SWIPE_THRESHOLD: cfg_reg.swipe_threshold <= cfg_data[7:0];
                REG_LOCK_SAMPLES:    cfg_reg.lock_samples    <= cfg_data[7:0];
                REG_BLINK_PERIOD:    cfg_reg.blink_period    <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/sgms_engine.sv]
`timescale 1ns / 1ps

module sgms_engine
    import sgms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic        primed_reg,     primed_next;
    logic [7:0]  prev_left_reg,  prev_left_next;
    logic [7:0]  prev_right_reg, prev_right_next;
    logic        locked_reg,     locked_next;
    logic [7:0]  lock_cnt_reg,   lock_cnt_next;
    logic [1:0]  entry_reg,      entry_next;
    logic        blink_en_reg,   blink_en_next;
    logic        phase_reg,      phase_next;
    logic [15:0] tick_cnt_reg,   tick_cnt_next;
    logic [2:0]  led_reg,        led_next;

    logic signed [9:0] rise_l;
    logic signed [9:0] rise_r;
    logic signed [9:0] thresh;
    logic              swipe_next;
    logic              swipe_prev;
    logic              lock_mid;
    logic [7:0]        lock_inc;
    logic [15:0]       tick_inc;
    logic [1:0]        seen;

    // Signed channel rises against the threshold
    assign rise_l = $signed({2'b00, item.left_level})  - $signed({2'b00, prev_left_reg});
    assign rise_r = $signed({2'b00, item.right_level}) - $signed({2'b00, prev_right_reg});
    assign thresh = $signed({2'b00, cfg.swipe_threshold});

    assign swipe_next = !locked_reg && (rise_r > thresh) && (rise_r > rise_l);
    assign swipe_prev = !locked_reg && !swipe_next && (rise_l > thresh) && (rise_l > rise_r);
    assign lock_mid   = locked_reg || swipe_next || swipe_prev;
    assign lock_inc   = lock_cnt_reg + 8'd1;
    assign tick_inc   = tick_cnt_reg + 16'd1;

    // Next state for one sample or tick
    always_comb
    begin
        primed_next     = primed_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        locked_next     = locked_reg;
        lock_cnt_next   = lock_cnt_reg;
        entry_next      = entry_reg;
        blink_en_next   = blink_en_reg;
        phase_next      = phase_reg;
        tick_cnt_next   = tick_cnt_reg;
        led_next        = led_reg;
        seen            = GEST_NONE;

        if (item.action == ACT_TICK)
        begin
            if (blink_en_reg)
            begin
                if (tick_inc >= cfg.blink_period)
                begin
                    tick_cnt_next = 16'd0;
                    phase_next    = !phase_reg;
                    led_next[1]   = !phase_reg;
                end
                else
                begin
                    tick_cnt_next = tick_inc;
                end
            end
        end
        else if (!primed_reg)
        begin
            // first sample only primes the history
            primed_next     = 1'b1;
            prev_left_next  = item.left_level;
            prev_right_next = item.right_level;
        end
        else
        begin
            prev_left_next  = item.left_level;
            prev_right_next = item.right_level;

            if (swipe_next || swipe_prev)
            begin
                if (swipe_next)
                begin
                    entry_next = entry_reg + 2'd1;
                    seen       = GEST_NEXT;
                end
                else
                begin
                    entry_next = entry_reg - 2'd1;
                    seen       = GEST_PREV;
                end

                // LED pattern on entering the new entry
                case (entry_next)
                    ENTRY_ZERO:
                    begin
                        blink_en_next = 1'b0;
                        led_next      = 3'b001;
                    end
                    ENTRY_ONE:
                    begin
                        blink_en_next = 1'b0;
                        led_next      = 3'b010;
                    end
                    ENTRY_BLINK:
                    begin
                        blink_en_next = 1'b1;
                        phase_next    = 1'b0;
                        led_next      = led_reg & 3'b010;
                    end
                    default:
                    begin
                        blink_en_next = 1'b0;
                        led_next      = 3'b100;
                    end
                endcase
            end

            // lockout count, including the detecting sample
            if (lock_mid)
            begin
                if (lock_inc > cfg.lock_samples)
                begin
                    locked_next   = 1'b0;
                    lock_cnt_next = 8'd0;
                end
                else
                begin
                    locked_next   = 1'b1;
                    lock_cnt_next = lock_inc;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg     <= 1'b0;
            prev_left_reg  <= 8'd0;
            prev_right_reg <= 8'd0;
            locked_reg     <= 1'b0;
            lock_cnt_reg   <= 8'd0;
            entry_reg      <= ENTRY_ZERO;
            blink_en_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            tick_cnt_reg   <= 16'd0;
            led_reg        <= 3'b000;
        end
        else if (step_en)
        begin
            primed_reg     <= primed_next;
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            locked_reg     <= locked_next;
            lock_cnt_reg   <= lock_cnt_next;
            entry_reg      <= entry_next;
            blink_en_reg   <= blink_en_next;
            phase_reg      <= phase_next;
            tick_cnt_reg   <= tick_cnt_next;
            led_reg        <= led_next;
        end
    end

    // Result reflects the state after this item
    assign result.menu_entry   = entry_next;
    assign result.gesture_seen = seen;
    assign result.led_one      = led_next[0];
    assign result.led_two      = led_next[1];
    assign result.led_three    = led_next[2];

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sgms_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 218;
    // Index 3 decodes to no register
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // Register settings per random phase; the first matches reset values
    localparam logic [7:0]  THR_TAB    [NUM_PHASES] = '{8'd82, 8'd0, 8'd255, 8'd40,
                                                        8'd100, 8'd20, 8'd60};
    localparam logic [7:0]  LOCK_TAB   [NUM_PHASES] = '{8'd20, 8'd0, 8'd254, 8'd3,
                                                        8'd10, 8'd1, 8'd5};
    localparam logic [15:0] PERIOD_TAB [NUM_PHASES] = '{16'd15, 16'd1, 16'd65535, 16'd2,
                                                        16'd7, 16'd4, 16'd3};

    // Predicts the menu / LED state and checks each result beat in order
    class menu_scoreboard;
        logic [7:0]  swipe_thr;
        logic [7:0]  lock_limit;
        logic [15:0] blink_len;
        bit          primed;
        logic [7:0]  last_left;
        logic [7:0]  last_right;
        bit          locked;
        logic [7:0]  lock_tally;
        logic [1:0]  entry;
        bit          blink_on;
        bit          blink_phase;
        logic [15:0] tick_count;
        logic [2:0]  leds;          // [0] LED one, [1] LED two, [2] LED three
        result_t     menu_results_q[$];
        int          errors;

        function new();
            swipe_thr   = SWIPE_THRESHOLD_RST;
            lock_limit  = LOCK_SAMPLES_RST;
            blink_len   = BLINK_PERIOD_RST;
            primed      = 1'b0;
            last_left   = '0;
            last_right  = '0;
            locked      = 1'b0;
            lock_tally  = '0;
            entry       = ENTRY_ZERO;
            blink_on    = 1'b0;
            blink_phase = 1'b0;
            tick_count  = '0;
            leds        = 3'b000;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SWIPE_THRESHOLD: swipe_thr  = data[7:0];
                REG_LOCK_SAMPLES:    lock_limit = data[7:0];
                REG_BLINK_PERIOD:    blink_len  = data;
                default: ;
            endcase
        endfunction

        // Gesture detected: move to entry e, set LEDs, start lockout
        function void enter_menu(logic [1:0] e);
            entry  = e;
            locked = 1'b1;
            case (e)
                ENTRY_ZERO:  begin blink_on = 1'b0; leds = 3'b001; end
                ENTRY_ONE:   begin blink_on = 1'b0; leds = 3'b010; end
                ENTRY_THREE: begin blink_on = 1'b0; leds = 3'b100; end
                default:
                begin
                    // LED two keeps its level until the next toggle
                    blink_on    = 1'b1;
                    blink_phase = 1'b0;
                    leds        = leds & 3'b010;
                end
            endcase
        endfunction

        function void note_item(item_t it);
            result_t    want;
            logic [1:0] seen;
            int         rise_l;
            int         rise_r;
            int         thr;
            seen = GEST_NONE;
            if (it.action == ACT_TICK) begin
                if (blink_on) begin
                    tick_count = tick_count + 16'd1;
                    if (tick_count >= blink_len) begin
                        tick_count  = '0;
                        blink_phase = ~blink_phase;
                        leds[1]     = blink_phase;
                    end
                end
            end else if (!primed) begin
                // first sample only loads the previous levels
                last_left  = it.left_level;
                last_right = it.right_level;
                primed     = 1'b1;
            end else begin
                rise_l = int'(it.left_level) - int'(last_left);
                rise_r = int'(it.right_level) - int'(last_right);
                thr    = int'(swipe_thr);
                if (!locked) begin
                    if (rise_r > thr && rise_r > rise_l) begin
                        enter_menu(entry + 2'd1);
                        seen = GEST_NEXT;
                    end else if (rise_l > thr && rise_l > rise_r) begin
                        enter_menu(entry - 2'd1);
                        seen = GEST_PREV;
                    end
                end
                // lockout count includes the detecting sample
                if (locked) begin
                    lock_tally = lock_tally + 8'd1;
                    if (lock_tally > lock_limit) begin
                        locked     = 1'b0;
                        lock_tally = '0;
                    end
                end
                last_left  = it.left_level;
                last_right = it.right_level;
            end
            want.menu_entry   = entry;
            want.gesture_seen = seen;
            want.led_one      = leds[0];
            want.led_two      = leds[1];
            want.led_three    = leds[2];
            menu_results_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [1:0] want, logic [1:0] got);
            if (got !== want) begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (menu_results_q.size() == 0) begin
                $error("result beat with no item outstanding");
                errors++;
            end else begin
                want = menu_results_q.pop_front();
                compare_field("menu_entry", want.menu_entry, got.menu_entry);
                compare_field("gesture_seen", want.gesture_seen, got.gesture_seen);
                compare_field("led_one", {1'b0, want.led_one}, {1'b0, got.led_one});
                compare_field("led_two", {1'b0, want.led_two}, {1'b0, got.led_two});
                compare_field("led_three", {1'b0, want.led_three}, {1'b0, got.led_three});
            end
        endfunction

        function int pending();
            return menu_results_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    item_t                  item;
    logic                   result_valid;
    logic                   result_ready;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    menu_scoreboard sb;
    bit idle_on;
    int gap_pct;
    int stall_pct;
    bit hold_long;
    bit peak;

    swipe_gesture_menu_selector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: errors");
        $finish;
    end

    // Beat monitor: values read here are the ones before the edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (item_valid && item_ready)
                sb.note_item(item);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // Result side: ready runs, random stall bursts, one long hold-off
    initial
    begin
        forever begin
            if (hold_long) begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic item_t sample_of(logic [7:0] l, logic [7:0] r);
        item_t it;
        it.action      = ACT_SAMPLE;
        it.left_level  = l;
        it.right_level = r;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        if (idle_on && $urandom_range(0, 99) < gap_pct) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    // Let every outstanding result drain before touching registers
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes all three registers plus the unused index
    task automatic write_config(input logic [7:0] thr, input logic [7:0] lock,
                                input logic [15:0] period);
        logic [CFG_DATA_W-1:0] v;
        v = {8'($urandom), thr};
        cfg_we    <= 1'b1;
        cfg_index <= REG_SWIPE_THRESHOLD;
        cfg_data  <= v;
        sb.write_reg(REG_SWIPE_THRESHOLD, v);
        @(posedge clk);
        v = {8'($urandom), lock};
        cfg_index <= REG_LOCK_SAMPLES;
        cfg_data  <= v;
        sb.write_reg(REG_LOCK_SAMPLES, v);
        @(posedge clk);
        cfg_index <= REG_BLINK_PERIOD;
        cfg_data  <= period;
        sb.write_reg(REG_BLINK_PERIOD, period);
        @(posedge clk);
        v = 16'($urandom);
        cfg_index <= REG_UNUSED;
        cfg_data  <= v;
        sb.write_reg(REG_UNUSED, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly baseline / swipe pairs, plus ticks and raw noise
    task automatic run_phase(input int n);
        item_t it;
        int    r;
        int    m;
        logic [7:0] hi;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            it = sample_of(8'($urandom), 8'($urandom));
            if (r < 22) begin
                it.action = ACT_TICK;
            end else if (r < 36) begin
                peak = 1'b0;
            end else if (peak) begin
                it.left_level  = 8'($urandom_range(0, 40));
                it.right_level = 8'($urandom_range(0, 40));
                peak = 1'b0;
            end else begin
                m  = $urandom_range(0, 9);
                hi = 8'($urandom_range(200, 255));
                if (m < 4) begin
                    it.right_level = hi;
                    it.left_level  = 8'($urandom_range(0, 60));
                end else if (m < 8) begin
                    it.left_level  = hi;
                    it.right_level = 8'($urandom_range(0, 60));
                end else if (m == 8) begin
                    it.left_level  = hi;
                    it.right_level = hi;
                end else begin
                    it.left_level  = 8'($urandom_range(150, 255));
                    it.right_level = 8'($urandom_range(150, 255));
                end
                peak = 1'b1;
            end
            send_item(it);
        end
    endtask

    initial
    begin
        int    k;
        item_t tick;
        sb         = new();
        idle_on    = 1'b0;
        gap_pct    = 0;
        stall_pct  = 0;
        hold_long  = 1'b0;
        peak       = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_SWIPE_THRESHOLD;
        cfg_data   <= '0;
        tick.action      = ACT_TICK;
        tick.left_level  = 8'hA5;
        tick.right_level = 8'h5A;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values: idle tick, priming, swipe, locked swipe
        send_item(tick);
        send_item(sample_of(8'd255, 8'd0));
        send_item(sample_of(8'd0, 8'd255));
        send_item(sample_of(8'd255, 8'd0));
        wait_idle();

        // Directed, lockout of one sample and fastest blink
        write_config(8'd82, 8'd0, 16'd1);
        send_item(sample_of(8'd255, 8'd0));     // lock runs out
        send_item(sample_of(8'd255, 8'd255));   // next -> blinking entry
        send_item(tick);
        send_item(tick);
        send_item(sample_of(8'd0, 8'd0));
        send_item(sample_of(8'd83, 8'd0));      // rise just over threshold
        send_item(sample_of(8'd83, 8'd82));     // rise equal to threshold
        send_item(sample_of(8'd83, 8'd165));
        send_item(sample_of(8'd173, 8'd255));   // equal rises on both sides
        send_item(sample_of(8'd0, 8'd0));
        send_item(sample_of(8'd100, 8'd0));
        send_item(sample_of(8'd0, 8'd0));
        send_item(sample_of(8'd100, 8'd0));     // back to entry zero
        send_item(sample_of(8'd0, 8'd0));
        send_item(sample_of(8'd100, 8'd0));     // wraps to entry three
        send_item(sample_of(8'd100, 8'd100));   // wraps to entry zero
        send_item(tick);
        wait_idle();

        // Random phases, one register setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_config(THR_TAB[p], LOCK_TAB[p], PERIOD_TAB[p]);
            idle_on   = (p != NUM_PHASES - 1);
            gap_pct   = $urandom_range(5, 35);
            stall_pct = $urandom_range(5, 35);
            hold_long = (p == 0);
            run_phase(PHASE_ITEMS);
            wait_idle();
        end

        item_valid <= 1'b0;
        @(posedge clk);
        for (k = 0; k < 500 && sb.pending() != 0; k++) @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/sgms_pkg.sv
rtl/sgms_cfg.sv
rtl/sgms_engine.sv
rtl/swipe_gesture_menu_selector.sv
dv/tb.sv
